// ===== sv/palette_ram_with_reverse_lookup_unit_macros.svh =====
// Assertion macros shared by the palette block's checker.
// Depends on nothing; included by the checker file only.
`ifndef PALETTE_RAM_WITH_REVERSE_LOOKUP_UNIT_MACROS_SVH
`define PALETTE_RAM_WITH_REVERSE_LOOKUP_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PAL_ASSERT_NOW(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |-> (c)) \
        else $error("palette checker: same-cycle rule violated");

// Next-cycle implication, disabled during reset.
`define PAL_ASSERT_NEXT(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |=> (c)) \
        else $error("palette checker: next-cycle rule violated");

`endif

// ===== sv/pal_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the palette block with reverse lookup.
// Depends on nothing; used by the cell, the top level and the checker.
package pal_pkg;

    localparam int COLOR_W = 16;
    localparam int INDEX_W = 16;
    localparam int OP_W    = 2;

    localparam logic [COLOR_W-1:0] MISS_CODE = 16'hFFFF;

    typedef enum logic [OP_W-1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FIND  = 2'd2
    } op_t;

    // One word travelling along the cell chain.
    typedef struct packed {
        logic               valid;
        op_t                op;
        logic [INDEX_W-1:0] index;
        logic [COLOR_W-1:0] color;
        logic [COLOR_W-1:0] result;
        logic               found;
    } token_t;

endpackage

// ===== sv/pal_cell.sv =====
`timescale 1ns / 1ps
// One palette cell: holds a single colour entry and passes the word on.
// Depends on pal_pkg.
module pal_cell
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [pal_pkg::INDEX_W-1:0] pos,
    input  pal_pkg::token_t             tok_in,
    output pal_pkg::token_t             tok_out
);

    logic [pal_pkg::COLOR_W-1:0] entry_reg;
    logic [pal_pkg::COLOR_W-1:0] entry_next;
    pal_pkg::token_t             tok_reg;
    pal_pkg::token_t             tok_next;

    always_comb
    begin
        tok_next   = tok_in;
        entry_next = entry_reg;
        if (tok_in.valid)
        begin
            unique case (tok_in.op)
                pal_pkg::OP_READ:
                begin
                    if (tok_in.index == pos)
                    begin
                        tok_next.result = entry_reg;
                    end
                end
                pal_pkg::OP_WRITE:
                begin
                    if (tok_in.index == pos)
                    begin
                        entry_next = tok_in.color;
                    end
                end
                pal_pkg::OP_FIND:
                begin
                    // Only the lowest matching cell claims the word.
                    if (!tok_in.found && (entry_reg == tok_in.color))
                    begin
                        tok_next.found  = 1'b1;
                        tok_next.result = pos;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            tok_reg   <= '0;
        end
        else if (advance)
        begin
            entry_reg <= entry_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== sv/palette_ram_with_reverse_lookup_unit.sv =====
`timescale 1ns / 1ps
// Top level of the palette memory with first-match reverse lookup.
// Depends on pal_pkg and pal_cell.
//
// The palette is a row of PALETTE_ENTRIES cells, each holding one 16-bit
// colour entry that reset clears to zero. Every accepted word (a read, a write
// or a find) enters cell 0 and moves one cell further in each cycle the chain
// advances; each cell acts on the word as it passes, so a read picks up its
// entry, a write lands in its cell and a find is claimed by the first cell
// whose colour matches. A word passes the PALETTE_ENTRIES cell registers, the
// first of which loads it at the accepting edge, and then the output register,
// after which its result is offered. A new word may be accepted in every cycle
// in which in_stall is low, since the order of words along the chain is the
// order in which they act on the entries. The whole chain holds still while a
// finished result waits on out_stall, and in_stall is high exactly then. Reads
// of out-of-range indexes return zero, out-of-range writes and the unused
// operation code change nothing, and a find with no match returns 16'hFFFF
// with found low.
module palette_ram_with_reverse_lookup_unit
#(
    parameter int PALETTE_ENTRIES = 256
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [pal_pkg::OP_W-1:0]    operation,
    input  logic [pal_pkg::INDEX_W-1:0] entry_index,
    input  logic [pal_pkg::COLOR_W-1:0] color_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [pal_pkg::COLOR_W-1:0] result_value,
    output logic                        found
);

    // Word at the entry and at the end of every cell.
    pal_pkg::token_t tok [0:PALETTE_ENTRIES];

    logic                        advance;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [pal_pkg::COLOR_W-1:0] result_reg;
    logic [pal_pkg::COLOR_W-1:0] result_next;
    logic                        found_reg;
    logic                        found_next;

    // The chain moves whenever the output register is free or being taken.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    // A find starts out as a miss; every other word starts with a zero result.
    always_comb
    begin
        tok[0].valid  = in_valid;
        tok[0].op     = pal_pkg::op_t'(operation);
        tok[0].index  = entry_index;
        tok[0].color  = color_value;
        tok[0].found  = 1'b0;
        tok[0].result = (pal_pkg::op_t'(operation) == pal_pkg::OP_FIND)
                        ? pal_pkg::MISS_CODE : '0;
    end

    for (genvar k = 0; k < PALETTE_ENTRIES; k++)
    begin : g_cell
        pal_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .pos     (pal_pkg::INDEX_W'(k)),
            .tok_in  (tok[k]),
            .tok_out (tok[k+1])
        );
    end

    // Output register: holds the finished word until it is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        found_next     = found_reg;
        if (advance)
        begin
            out_valid_next = tok[PALETTE_ENTRIES].valid;
            result_next    = tok[PALETTE_ENTRIES].result;
            found_next     = tok[PALETTE_ENTRIES].found;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        found_reg  <= found_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign found        = found_reg;

endmodule

// ===== sv/pal_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the palette block, bound to its top level.
// Depends on pal_pkg and the shared assertion macro header.
`include "palette_ram_with_reverse_lookup_unit_macros.svh"

module pal_checker
#(
    parameter int PALETTE_ENTRIES = 256
)
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [pal_pkg::COLOR_W-1:0] result_value,
    input logic                        found
);

    localparam logic [pal_pkg::COLOR_W-1:0] LAST_INDEX =
        pal_pkg::COLOR_W'(PALETTE_ENTRIES - 1);

    // The input side is held back only by a result that waits to be taken.
    `PAL_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

    // A hit always names an entry that exists.
    `PAL_ASSERT_NOW(a_hit_in_range, clk, rst_n, out_valid && found, result_value <= LAST_INDEX)

    // A stalled result stays offered.
    `PAL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    // A stalled result keeps its value.
    `PAL_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(result_value) && $stable(found))

endmodule

bind palette_ram_with_reverse_lookup_unit pal_checker
#(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
)
u_pal_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .found        (found)
);
